>>> hdl/rfc_pkg.sv
// Package with the constants, codes and shared types of the RAM-file I/O card block.
`default_nettype none
package rfc_pkg;

  // Card sizes in bytes.
  localparam int CARD_A_BYTES    = 65536;
  localparam int CARD_B_BYTES    = 32768;
  localparam int EXPANSION_BYTES = 327680;

  // Pointer widths.
  localparam int A_PTR_W = 16;
  localparam int B_PTR_W = 15;
  localparam int X_PTR_W = 19;

  // Memory index widths.
  localparam int A_AW = $clog2(CARD_A_BYTES);
  localparam int B_AW = $clog2(CARD_B_BYTES);
  localparam int X_AW = $clog2(EXPANSION_BYTES);

  // Bus access kinds.
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Decoded low address bytes.
  localparam logic [7:0] PORT_A_DATA = 8'hEA;
  localparam logic [7:0] PORT_A_PTR  = 8'hEB;
  localparam logic [7:0] PORT_B_PTRH = 8'hF8;
  localparam logic [7:0] PORT_B_PTRL = 8'hF9;
  localparam logic [7:0] PORT_B_WDAT = 8'hFA;
  localparam logic [7:0] PORT_X_PTR0 = 8'h00;
  localparam logic [7:0] PORT_X_PTR1 = 8'h01;
  localparam logic [7:0] PORT_X_PTR2 = 8'h02;
  localparam logic [7:0] PORT_X_DATA = 8'h03;

  // Source of the read data in the result stage.
  localparam logic [1:0] SEL_IMM = 2'd0;
  localparam logic [1:0] SEL_A   = 2'd1;
  localparam logic [1:0] SEL_B   = 2'd2;
  localparam logic [1:0] SEL_X   = 2'd3;

  typedef struct packed {
    logic            rd;
    logic            wr;
    logic [A_AW-1:0] addr;
    logic [7:0]      wdata;
  } a_req_t;

  typedef struct packed {
    logic            rd;
    logic            wr;
    logic [B_AW-1:0] addr;
    logic [7:0]      wdata;
  } b_req_t;

  typedef struct packed {
    logic            rd;
    logic            wr;
    logic [X_AW-1:0] addr;
    logic [7:0]      wdata;
  } x_req_t;

  // Result bookkeeping carried to the result stage.
  typedef struct packed {
    logic       hit;
    logic [1:0] sel;
    logic [7:0] imm;
  } res_t;

endpackage
`default_nettype wire

>>> hdl/rfc_if.sv
// Valid/ready channel interfaces for the bus request and the result.
`default_nettype none
interface rfc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] port;
  logic [7:0] high_byte;
  logic [7:0] write_data;

  modport source (output valid, func, port, high_byte, write_data, input ready);
  modport sink   (input valid, func, port, high_byte, write_data, output ready);
endinterface

interface rfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       responded;

  modport source (output valid, read_data, responded, input ready);
  modport sink   (input valid, read_data, responded, output ready);
endinterface
`default_nettype wire

>>> hdl/ramfile_io_port_memory_card.sv
// Top level of the three-card auto-increment RAM-file I/O block.
// A request passes the input register, then the result register beside the registered RAM
// read data, before its result can be accepted at the output.
// Throughput: one request per cycle; a waiting result lets one more request in, then stalls.
// Reset (rst_n, synchronous, active low) clears the three pointers and both valid flags.
// Memory contents are not cleared and stay undefined until written.
`default_nettype none
module ramfile_io_port_memory_card (
  input wire logic clk,
  input wire logic rst_n,
  rfc_in_if.sink   in_ch,
  rfc_out_if.source out_ch
);
  import rfc_pkg::*;

  // Input register. It holds one request while its decode and memory access run.
  logic       s1_valid_r;
  logic       s1_func_r;
  logic [7:0] s1_port_r;
  logic [7:0] s1_high_r;
  logic [7:0] s1_data_r;

  // Result register. The memory read data lives in the RAM's own output register
  // and is picked according to the select code kept here.
  logic s2_valid_r;
  res_t s2_res_r;

  logic   s1_advance;
  a_req_t a_req;
  b_req_t b_req;
  x_req_t x_req;
  res_t   s1_res;
  logic [7:0] a_rdata, b_rdata, x_rdata;
  logic [7:0] out_data;

  // The input stage moves on whenever the result register is empty or is being
  // emptied, so requests flow one per cycle while results drain. While a result
  // waits, one more request fits in the input register and then the input stalls.
  assign s1_advance  = s1_valid_r && (!s2_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_func_r <= in_ch.func;
      s1_port_r <= in_ch.port;
      s1_high_r <= in_ch.high_byte;
      s1_data_r <= in_ch.write_data;
    end
  end

  // Decode and pointer update. The pointers step at the edge the request leaves
  // the input register, so the next request already sees the new values.
  rfc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (s1_advance),
    .func       (s1_func_r),
    .port       (s1_port_r),
    .high_byte  (s1_high_r),
    .write_data (s1_data_r),
    .a_req      (a_req),
    .b_req      (b_req),
    .x_req      (x_req),
    .res        (s1_res)
  );

  // Card memories. A read only fires when the request advances, so the read
  // data holds steady while a result is stalled at the output.
  rfc_ram #(.DEPTH(CARD_A_BYTES)) u_ram_a (
    .clk   (clk),
    .rd    (a_req.rd),
    .wr    (a_req.wr),
    .addr  (a_req.addr),
    .wdata (a_req.wdata),
    .rdata (a_rdata)
  );

  rfc_ram #(.DEPTH(CARD_B_BYTES)) u_ram_b (
    .clk   (clk),
    .rd    (b_req.rd),
    .wr    (b_req.wr),
    .addr  (b_req.addr),
    .wdata (b_req.wdata),
    .rdata (b_rdata)
  );

  rfc_ram #(.DEPTH(EXPANSION_BYTES)) u_ram_x (
    .clk   (clk),
    .rd    (x_req.rd),
    .wr    (x_req.wr),
    .addr  (x_req.addr),
    .wdata (x_req.wdata),
    .rdata (x_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_advance) begin
      s2_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      s2_res_r <= s1_res;
    end
  end

  // Writes and undecoded reads carry a zero immediate and select it.
  always_comb begin
    case (s2_res_r.sel)
      SEL_A:   out_data = a_rdata;
      SEL_B:   out_data = b_rdata;
      SEL_X:   out_data = x_rdata;
      default: out_data = s2_res_r.imm;
    endcase
  end

  assign out_ch.valid     = s2_valid_r;
  assign out_ch.read_data = out_data;
  assign out_ch.responded = s2_res_r.hit;

  // Only one card is touched by any single request.
  a_ctrl_onecard: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({a_req.rd | a_req.wr, b_req.rd | b_req.wr, x_req.rd | x_req.wr}))
    else $error("more than one card accessed by one request");

  // A request that found no decoded read port returns zero data.
  a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.responded |-> out_ch.read_data == 8'h00)
    else $error("non-responding result carries data");

  // Memory data is only selected for a responding read.
  a_sel_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && s2_res_r.sel != SEL_IMM |-> out_ch.responded)
    else $error("memory data selected without a response");

  // A held request in the input register does not touch the memories.
  a_stall_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_advance |-> !(a_req.rd || a_req.wr || b_req.rd || b_req.wr ||
                                    x_req.rd || x_req.wr))
    else $error("memory accessed by a stalled request");

endmodule
`default_nettype wire

>>> hdl/rfc_ram.sv
// Generic single-port byte RAM with registered read data.
`default_nettype none
module rfc_ram #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rd,
  input  wire logic          wr,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [0:DEPTH-1];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[addr] <= wdata;
    end else if (rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> hdl/rfc_ctrl.sv
// Port decoder and pointer registers of the three cards.
`default_nettype none
module rfc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          advance,
  input  wire logic          func,
  input  wire logic [7:0]    port,
  input  wire logic [7:0]    high_byte,
  input  wire logic [7:0]    write_data,
  output rfc_pkg::a_req_t    a_req,
  output rfc_pkg::b_req_t    b_req,
  output rfc_pkg::x_req_t    x_req,
  output rfc_pkg::res_t      res
);
  import rfc_pkg::*;

  logic [A_PTR_W-1:0] a_ptr_r, a_ptr_nxt;
  logic [B_PTR_W-1:0] b_ptr_r, b_ptr_nxt;
  logic [X_PTR_W-1:0] x_ptr_r, x_ptr_nxt;
  logic [X_PTR_W-1:0] x_fold;
  logic a_acc, b_acc, x_acc;

  // The expansion pointer folds back by one card size before a data access.
  assign x_fold = (x_ptr_r >= X_PTR_W'(EXPANSION_BYTES)) ?
                  x_ptr_r - X_PTR_W'(EXPANSION_BYTES) : x_ptr_r;

  always_comb begin
    a_ptr_nxt = a_ptr_r;
    b_ptr_nxt = b_ptr_r;
    x_ptr_nxt = x_ptr_r;
    a_acc     = 1'b0;
    b_acc     = 1'b0;
    x_acc     = 1'b0;
    res       = '{hit: 1'b0, sel: SEL_IMM, imm: 8'h00};
    if (func == FUNC_WRITE) begin
      case (port)
        PORT_A_DATA: begin
          a_acc     = 1'b1;
          a_ptr_nxt = a_ptr_r + 1'b1;
        end
        PORT_A_PTR:  a_ptr_nxt = {high_byte, write_data};
        PORT_B_PTRH: b_ptr_nxt = {write_data[6:0], b_ptr_r[7:0]};
        PORT_B_PTRL: b_ptr_nxt = {b_ptr_r[14:8], write_data};
        PORT_B_WDAT: begin
          b_acc     = 1'b1;
          b_ptr_nxt = b_ptr_r + 1'b1;
        end
        PORT_X_PTR0: x_ptr_nxt = {x_ptr_r[18:8], write_data};
        PORT_X_PTR1: x_ptr_nxt = {x_ptr_r[18:16], write_data, x_ptr_r[7:0]};
        PORT_X_PTR2: x_ptr_nxt = {write_data[2:0], x_ptr_r[15:0]};
        PORT_X_DATA: begin
          x_acc     = 1'b1;
          x_ptr_nxt = x_fold + 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (port)
        PORT_A_DATA: begin
          a_acc     = 1'b1;
          a_ptr_nxt = a_ptr_r + 1'b1;
          res.hit   = 1'b1;
          res.sel   = SEL_A;
        end
        PORT_A_PTR: begin
          res.hit = 1'b1;
          res.imm = a_ptr_r[7:0];
        end
        PORT_B_PTRH: begin
          b_ptr_nxt = '0;
          res.hit   = 1'b1;
        end
        PORT_B_PTRL: begin
          b_acc     = 1'b1;
          b_ptr_nxt = b_ptr_r + 1'b1;
          res.hit   = 1'b1;
          res.sel   = SEL_B;
        end
        PORT_X_DATA: begin
          x_acc     = 1'b1;
          x_ptr_nxt = x_fold + 1'b1;
          res.hit   = 1'b1;
          res.sel   = SEL_X;
        end
        default: ;
      endcase
    end
  end

  assign a_req = '{rd: advance && a_acc && (func == FUNC_READ),
                   wr: advance && a_acc && (func == FUNC_WRITE),
                   addr: a_ptr_r[A_AW-1:0], wdata: write_data};
  assign b_req = '{rd: advance && b_acc && (func == FUNC_READ),
                   wr: advance && b_acc && (func == FUNC_WRITE),
                   addr: b_ptr_r[B_AW-1:0], wdata: write_data};
  assign x_req = '{rd: advance && x_acc && (func == FUNC_READ),
                   wr: advance && x_acc && (func == FUNC_WRITE),
                   addr: x_fold[X_AW-1:0], wdata: write_data};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ptr_r <= '0;
      b_ptr_r <= '0;
      x_ptr_r <= '0;
    end else if (advance) begin
      a_ptr_r <= a_ptr_nxt;
      b_ptr_r <= b_ptr_nxt;
      x_ptr_r <= x_ptr_nxt;
    end
  end

endmodule
`default_nettype wire

>>> test/ramfile_io_port_memory_card_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the three-card RAM-file I/O block.
module ramfile_io_port_memory_card_test;
  import rfc_pkg::*;

  // Cycles to let the two-stage pipeline settle once nothing is outstanding.
  localparam int SETTLE_CYCLES    = 6;
  // Length of the long receiver hold-off that backs the block up into its input.
  localparam int LONG_HOLD_CYCLES = 300;
  // A low address byte that none of the cards decodes.
  localparam logic [7:0] UNUSED_PORT = 8'h55;

  typedef struct packed {
    logic       func;
    logic [7:0] port;
    logic [7:0] high_byte;
    logic [7:0] write_data;
  } bus_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       responded;
  } bus_resp_t;

  typedef enum logic {RX_RANDOM, RX_ALWAYS} rx_mode_t;
  typedef enum int {CARD_A, CARD_B, CARD_X} card_t;

  logic clk = 1'b0;
  logic rst_n;

  rfc_in_if  in_ch ();
  rfc_out_if out_ch ();

  ramfile_io_port_memory_card u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the card state. The pointers and memories change as each request
  // is accepted; the "written" flags keep the stimulus away from bytes that have
  // never been stored, since their contents are undefined.
  logic [15:0] a_ptr;
  logic [14:0] b_ptr;
  logic [18:0] x_ptr;
  logic [7:0]  a_mem [CARD_A_BYTES];
  logic [7:0]  b_mem [CARD_B_BYTES];
  logic [7:0]  x_mem [EXPANSION_BYTES];
  bit          a_set [CARD_A_BYTES];
  bit          b_set [CARD_B_BYTES];
  bit          x_set [EXPANSION_BYTES];

  // Responses still owed by the block, oldest first.
  bus_resp_t responses_due[$];

  int       error_count       = 0;
  int       decoded_requests  = 0;
  bit       tx_gaps           = 1'b1;
  rx_mode_t rx_mode           = RX_RANDOM;
  bit       hold_request      = 1'b0;

  // The expansion pointer folds back once into the 320 KiB range before any
  // data access; pointers from 0x50000 up land 0x50000 lower.
  function automatic logic [18:0] x_folded(logic [18:0] p);
    return (p >= EXPANSION_BYTES) ? 19'(p - EXPANSION_BYTES) : p;
  endfunction

  // Applies one bus access to the mirrored card state and returns the response
  // the block has to give for it.
  function automatic bus_resp_t apply_bus_access(bus_req_t r);
    bus_resp_t res;
    res = '0;
    if (r.func == FUNC_WRITE) begin
      case (r.port)
        PORT_A_DATA: begin
          a_mem[a_ptr] = r.write_data;
          a_set[a_ptr] = 1'b1;
          a_ptr        = a_ptr + 1'b1;
        end
        PORT_A_PTR:  a_ptr = {r.high_byte, r.write_data};
        PORT_B_PTRH: b_ptr[14:8] = r.write_data[6:0];
        PORT_B_PTRL: b_ptr[7:0] = r.write_data;
        PORT_B_WDAT: begin
          b_mem[b_ptr] = r.write_data;
          b_set[b_ptr] = 1'b1;
          b_ptr        = b_ptr + 1'b1;
        end
        PORT_X_PTR0: x_ptr[7:0] = r.write_data;
        PORT_X_PTR1: x_ptr[15:8] = r.write_data;
        PORT_X_PTR2: x_ptr[18:16] = r.write_data[2:0];
        PORT_X_DATA: begin
          x_ptr        = x_folded(x_ptr);
          x_mem[x_ptr] = r.write_data;
          x_set[x_ptr] = 1'b1;
          x_ptr        = x_ptr + 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (r.port)
        PORT_A_DATA: begin
          res.read_data = a_mem[a_ptr];
          res.responded = 1'b1;
          a_ptr         = a_ptr + 1'b1;
        end
        PORT_A_PTR: begin
          res.read_data = a_ptr[7:0];
          res.responded = 1'b1;
        end
        PORT_B_PTRH: begin
          b_ptr         = '0;
          res.responded = 1'b1;
        end
        PORT_B_PTRL: begin
          res.read_data = b_mem[b_ptr];
          res.responded = 1'b1;
          b_ptr         = b_ptr + 1'b1;
        end
        PORT_X_DATA: begin
          x_ptr         = x_folded(x_ptr);
          res.read_data = x_mem[x_ptr];
          res.responded = 1'b1;
          x_ptr         = x_ptr + 1'b1;
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // A data read is only allowed when the byte it would return has been stored.
  function automatic bit read_defined(logic [7:0] port);
    case (port)
      PORT_A_DATA: return a_set[a_ptr];
      PORT_B_PTRL: return b_set[b_ptr];
      PORT_X_DATA: return x_set[x_folded(x_ptr)];
      default:     return 1'b1;
    endcase
  endfunction

  function automatic bit is_decoded(bus_req_t r);
    if (r.func == FUNC_WRITE)
      return r.port inside {PORT_A_DATA, PORT_A_PTR, PORT_B_PTRH, PORT_B_PTRL, PORT_B_WDAT,
                            PORT_X_PTR0, PORT_X_PTR1, PORT_X_PTR2, PORT_X_DATA};
    return r.port inside {PORT_A_DATA, PORT_A_PTR, PORT_B_PTRH, PORT_B_PTRL, PORT_X_DATA};
  endfunction

  // Sender idle time: mostly none or a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    if (!tx_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one request and holds it until the block takes it. The expected
  // response is worked out at the accepting edge, before the result can be
  // accepted at the output. Valid stays high between back-to-back requests so
  // it is never dropped and raised again within one time step.
  task automatic issue_request(bus_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= r.func;
    in_ch.port       <= r.port;
    in_ch.high_byte  <= r.high_byte;
    in_ch.write_data <= r.write_data;
    do @(posedge clk); while (!in_ch.ready);
    responses_due.push_back(apply_bus_access(r));
    if (is_decoded(r)) decoded_requests++;
  endtask

  task automatic bus_write(logic [7:0] port, logic [7:0] data);
    bus_req_t r;
    r.func       = FUNC_WRITE;
    r.port       = port;
    r.high_byte  = 8'($urandom_range(0, 255));
    r.write_data = data;
    issue_request(r);
  endtask

  task automatic bus_read(logic [7:0] port);
    bus_req_t r;
    r.func       = FUNC_READ;
    r.port       = port;
    r.high_byte  = 8'($urandom_range(0, 255));
    r.write_data = 8'($urandom_range(0, 255));
    issue_request(r);
  endtask

  // Aims a card's pointer at an address. Card B can instead be sent to zero by
  // the clearing read of its high pointer port.
  task automatic point_card(card_t card, logic [18:0] p, bit via_clear);
    bus_req_t r;
    case (card)
      CARD_A: begin
        r.func       = FUNC_WRITE;
        r.port       = PORT_A_PTR;
        r.high_byte  = p[15:8];
        r.write_data = p[7:0];
        issue_request(r);
      end
      CARD_B: begin
        if (via_clear) begin
          bus_read(PORT_B_PTRH);
        end else begin
          // Bit 7 of the high byte is not part of the 15-bit pointer.
          bus_write(PORT_B_PTRH, {1'($urandom_range(0, 1)), p[14:8]});
          bus_write(PORT_B_PTRL, p[7:0]);
        end
      end
      default: begin
        bus_write(PORT_X_PTR0, p[7:0]);
        bus_write(PORT_X_PTR1, p[15:8]);
        bus_write(PORT_X_PTR2, {5'($urandom_range(0, 31)), p[18:16]});
      end
    endcase
  endtask

  // A well-formed card session: aim the pointer, store a run of bytes, aim it
  // back at the same place and read part of the run. Bases lean toward the top
  // of each card so pointer wrap and expansion fold come up often.
  task automatic run_card_burst();
    card_t       card;
    int          len;
    int          nread;
    logic [18:0] base;
    logic [7:0]  wport;
    logic [7:0]  rport;
    bit          via_clear;
    card      = card_t'($urandom_range(0, 2));
    len       = $urandom_range(1, 8);
    nread     = $urandom_range(1, len);
    via_clear = 1'b0;
    case (card)
      CARD_A: begin
        wport = PORT_A_DATA;
        rport = PORT_A_DATA;
        base  = ($urandom_range(0, 3) == 0) ? 19'(16'hFFFF - $urandom_range(0, 9))
                                            : 19'($urandom_range(0, 16'hFFFF));
      end
      CARD_B: begin
        wport     = PORT_B_WDAT;
        rport     = PORT_B_PTRL;
        via_clear = ($urandom_range(0, 4) == 0);
        base      = ($urandom_range(0, 3) == 0) ? 19'(15'h7FFF - $urandom_range(0, 9))
                                                : 19'($urandom_range(0, 15'h7FFF));
        if (via_clear) base = '0;
      end
      default: begin
        wport = PORT_X_DATA;
        rport = PORT_X_DATA;
        case ($urandom_range(0, 3))
          0:       base = 19'(20'h4FFFF - $urandom_range(0, 9));
          1:       base = 19'(20'h7FFFF - $urandom_range(0, 9));
          default: base = 19'($urandom_range(0, 20'h7FFFF));
        endcase
      end
    endcase
    point_card(card, base, via_clear);
    repeat (len) bus_write(wport, 8'($urandom_range(0, 255)));
    point_card(card, base, via_clear);
    repeat (nread) bus_read(rport);
  endtask

  // A loose request: any direction, mostly card ports but also undecoded ones.
  // A data read that would hit a never-written byte is turned into a write.
  task automatic issue_noise();
    bus_req_t r;
    r.func       = 1'($urandom_range(0, 1));
    r.high_byte  = 8'($urandom_range(0, 255));
    r.write_data = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 12))
      0:       r.port = PORT_A_DATA;
      1:       r.port = PORT_A_PTR;
      2:       r.port = PORT_B_PTRH;
      3:       r.port = PORT_B_PTRL;
      4:       r.port = PORT_B_WDAT;
      5:       r.port = PORT_X_PTR0;
      6:       r.port = PORT_X_PTR1;
      7:       r.port = PORT_X_PTR2;
      8:       r.port = PORT_X_DATA;
      default: r.port = 8'($urandom_range(0, 255));
    endcase
    if (r.func == FUNC_READ && !read_defined(r.port)) r.func = FUNC_WRITE;
    issue_request(r);
  endtask

  // Random traffic until n more decoded requests have gone in.
  task automatic run_traffic(int n);
    int target;
    target = decoded_requests + n;
    while (decoded_requests < target) begin
      if ($urandom_range(0, 9) < 7) run_card_burst();
      else issue_noise();
    end
  endtask

  // The sender stops and waits for every outstanding response, then lets the
  // pipeline settle.
  task automatic wait_for_responses();
    in_ch.valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Card A: pointer load from both address bytes, wrap at 0xFFFF, and the
  // pointer readback on the pointer port.
  task automatic test_card_a_edges();
    point_card(CARD_A, 19'h0FFFF, 1'b0);
    bus_write(PORT_A_DATA, 8'hFF);
    bus_write(PORT_A_DATA, 8'h00);
    bus_read(PORT_A_PTR);
    point_card(CARD_A, 19'h0FFFF, 1'b0);
    bus_read(PORT_A_DATA);
    bus_read(PORT_A_DATA);
  endtask

  // Card B: high pointer byte with bit 7 set, wrap from 0x7FFF to zero, and the
  // clearing read of the high pointer port.
  task automatic test_card_b_edges();
    bus_write(PORT_B_PTRH, 8'hFF);
    bus_write(PORT_B_PTRL, 8'hFF);
    bus_write(PORT_B_WDAT, 8'h5A);
    bus_write(PORT_B_WDAT, 8'h3C);
    bus_read(PORT_B_PTRH);
    bus_read(PORT_B_PTRL);
  endtask

  // Expansion card: the largest pointer and exactly 0x50000 both fold before
  // the access; the readbacks go through the same folds.
  task automatic test_expansion_fold();
    point_card(CARD_X, 19'h7FFFF, 1'b0);
    bus_write(PORT_X_DATA, 8'h77);
    bus_write(PORT_X_PTR2, 8'h05);
    bus_write(PORT_X_DATA, 8'h81);
    point_card(CARD_X, 19'h7FFFF, 1'b0);
    bus_read(PORT_X_DATA);
    bus_write(PORT_X_PTR2, 8'hFD);
    bus_read(PORT_X_DATA);
  endtask

  // Reads of a write-only pointer port and accesses to an unused port must
  // come back silent and leave the cards alone.
  task automatic test_undecoded_ports();
    bus_read(PORT_X_PTR0);
    bus_read(UNUSED_PORT);
    bus_write(UNUSED_PORT, 8'hFF);
  endtask

  // Random traffic with both sides idling at random.
  task automatic test_random_traffic(int n);
    tx_gaps = 1'b1;
    rx_mode = RX_RANDOM;
    run_traffic(n);
  endtask

  // No idling on either side: one request per cycle for as long as it lasts.
  task automatic test_back_to_back(int n);
    tx_gaps = 1'b0;
    rx_mode = RX_ALWAYS;
    run_traffic(n);
    rx_mode = RX_RANDOM;
    tx_gaps = 1'b1;
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // requests, so the block fills up and has to stall its input.
  task automatic test_input_stall(int n);
    tx_gaps      = 1'b0;
    hold_request = 1'b1;
    run_traffic(n);
    tx_gaps      = 1'b1;
  endtask

  // Result receiver. Ready alternates between runs of acceptance and stalls,
  // mostly short with the odd long one; a long hold-off can be requested and is
  // counted down here.
  initial begin
    int   run_left;
    int   hold_left;
    logic level;
    run_left  = 0;
    hold_left = 0;
    level     = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_mode == RX_ALWAYS) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          level = !level;
          if (level) run_left = $urandom_range(1, 12);
          else run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
        end
        run_left--;
        out_ch.ready <= level;
      end
    end
  end

  // Response checker: every accepted response is matched against the oldest
  // outstanding request's expectation, field by field.
  always @(posedge clk) begin
    bus_resp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (responses_due.size() == 0) begin
        $error("response with no request outstanding: read_data %h responded %b",
               out_ch.read_data, out_ch.responded);
        error_count++;
      end else begin
        want = responses_due.pop_front();
        if (out_ch.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_ch.read_data);
          error_count++;
        end
        if (out_ch.responded !== want.responded) begin
          $error("responded: expected %b, got %b", want.responded, out_ch.responded);
          error_count++;
        end
      end
    end
  end

  // Main sequence: reset once, corner cases, then the random phases with a full
  // drain between them.
  initial begin
    a_ptr = '0;
    b_ptr = '0;
    x_ptr = '0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_READ;
    in_ch.port       <= '0;
    in_ch.high_byte  <= '0;
    in_ch.write_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_card_a_edges();
    test_card_b_edges();
    test_expansion_fold();
    test_undecoded_ports();
    wait_for_responses();

    test_random_traffic(700);
    wait_for_responses();
    test_back_to_back(300);
    wait_for_responses();
    test_input_stall(100);
    wait_for_responses();
    test_random_traffic(650);
    wait_for_responses();

    if (error_count == 0) begin
      $display("ramfile_io_port_memory_card_test: clean");
    end else begin
      $display("ramfile_io_port_memory_card_test: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("ramfile_io_port_memory_card_test: errors");
    $finish;
  end

endmodule

>>> files.f
hdl/rfc_pkg.sv
hdl/rfc_if.sv
hdl/rfc_ram.sv
hdl/rfc_ctrl.sv
hdl/ramfile_io_port_memory_card.sv
test/ramfile_io_port_memory_card_test.sv
